// ===== design/ppm_p6_to_rgb565_stream_decoder_core_macros.svh =====
// Assertion macros shared by the decoder modules.
// No dependencies; included by the files that carry concurrent checks.
`ifndef PPM_P6_TO_RGB565_STREAM_DECODER_CORE_MACROS_SVH
`define PPM_P6_TO_RGB565_STREAM_DECODER_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PPD_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ppd: invariant violated");

// Condition in one cycle implies a consequence in the next.
`define PPD_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("ppd: next-cycle check failed");

`endif

// ===== design/ppd_pkg.sv =====
// Shared types and constants for the PPM P6 to RGB565 decoder.
// No dependencies; imported by every decoder module.
package ppd_pkg;

  // header limits
  localparam int MAX_DIM       = 4096;
  localparam int MAX_DIGITS    = 5;
  localparam int TOKEN_LEN_SAT = 6;

  // default queue depths
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  // byte codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_MAGIC     = 3'd0;
  localparam logic [2:0] ERR_HDR_TRUNC = 3'd1;
  localparam logic [2:0] ERR_DIMS      = 3'd2;
  localparam logic [2:0] ERR_MAXVAL    = 3'd3;
  localparam logic [2:0] ERR_PIX_TRUNC = 3'd4;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_space;
    logic       is_lf;
    logic       is_hash;
    logic       is_digit;
  } cmd_t;

  // one result request
  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] width;
    logic [12:0] height;
    logic [15:0] rgb565;
    logic [2:0]  error_code;
    logic        final_res;
  } res_t;

  function automatic res_t make_res(logic [1:0] kind, logic [12:0] w, logic [12:0] h,
                                    logic [15:0] px, logic [2:0] err, logic fin);
    res_t r;
    r.kind       = kind;
    r.width      = w;
    r.height     = h;
    r.rgb565     = px;
    r.error_code = err;
    r.final_res  = fin;
    return r;
  endfunction

endpackage

// ===== design/ppd_front.sv =====
// Front end: takes input byte requests and classifies each byte.
// Depends on ppd_pkg; feeds ppd_cmdq.
module ppd_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_input_i,
  input  logic          q_full_i,
  output logic          push_o,
  output ppd_pkg::cmd_t cmd_o
);
  import ppd_pkg::*;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.data     = data_byte_i;
    cmd_o.last     = end_of_input_i;
    cmd_o.is_space = (data_byte_i == CH_SPACE) || (data_byte_i == CH_TAB) ||
                     (data_byte_i == CH_CR)    || (data_byte_i == CH_LF);
    cmd_o.is_lf    = (data_byte_i == CH_LF);
    cmd_o.is_hash  = (data_byte_i == CH_HASH);
    cmd_o.is_digit = (data_byte_i >= CH_ZERO) && (data_byte_i <= CH_NINE);
  end

endmodule

// ===== design/ppd_cmdq.sv =====
// Short queue of classified bytes between front and back.
// Depends on ppd_pkg for cmd_t.
module ppd_cmdq #(
  parameter int DEPTH = ppd_pkg::CMD_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ppd_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ppd_pkg::cmd_t data_o
);
  import ppd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/ppd_back.sv =====
// Back end: header parser, pixel packer and result generation.
// Depends on ppd_pkg and the assertion macro header.
`include "ppm_p6_to_rgb565_stream_decoder_core_macros.svh"

module ppd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  ppd_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_space_i,
  output logic [1:0]    res_push_n_o,
  output ppd_pkg::res_t res0_o,
  output ppd_pkg::res_t res1_o
);
  import ppd_pkg::*;

  typedef enum logic [2:0] {
    PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS, PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        in_comment_q, in_comment_d;
  logic        in_token_q, in_token_d;
  logic [2:0]  tok_len_q, tok_len_d;
  logic [16:0] tok_val_q, tok_val_d;
  logic        tok_nd_q, tok_nd_d;
  logic        magic_q, magic_d;
  logic [12:0] width_q, width_d;
  logic [12:0] height_q, height_d;
  logic        dims_bad_q, dims_bad_d;
  logic [1:0]  chan_q, chan_d;
  logic [4:0]  red_q, red_d;
  logic [5:0]  green_q, green_d;
  logic [24:0] pix_left_q, pix_left_d;

  logic        fire;
  logic [24:0] area;
  logic        do_add, do_fin, dim_ok;
  logic [16:0] val_x10;
  logic [15:0] px;
  logic        a_vld, b_vld;
  res_t        res_a, res_b;

  assign fire      = cmd_valid_i && res_space_i;
  assign cmd_pop_o = fire;
  assign area      = 25'(width_q) * 25'(height_q);

  always_comb begin
    phase_d      = phase_q;
    in_comment_d = in_comment_q;
    in_token_d   = in_token_q;
    tok_len_d    = tok_len_q;
    tok_val_d    = tok_val_q;
    tok_nd_d     = tok_nd_q;
    magic_d      = magic_q;
    width_d      = width_q;
    height_d     = height_q;
    dims_bad_d   = dims_bad_q;
    chan_d       = chan_q;
    red_d        = red_q;
    green_d      = green_q;
    pix_left_d   = pix_left_q;
    do_add       = 1'b0;
    do_fin       = 1'b0;
    dim_ok       = 1'b0;
    val_x10      = '0;
    px           = '0;
    a_vld        = 1'b0;
    b_vld        = 1'b0;
    res_a        = '0;
    res_b        = '0;

    if (phase_q < PH_PIXELS) begin
      if (in_comment_q) begin
        if (cmd_i.is_lf) begin
          in_comment_d = 1'b0;
        end
      end else if (in_token_q) begin
        if (cmd_i.is_space) do_fin = 1'b1;
        else                do_add = 1'b1;
      end else if (!cmd_i.is_space) begin
        if (cmd_i.is_hash) begin
          in_comment_d = 1'b1;
        end else begin
          in_token_d = 1'b1;
          tok_len_d  = '0;
          tok_val_d  = '0;
          tok_nd_d   = 1'b0;
          magic_d    = 1'b1;
          do_add     = 1'b1;
        end
      end
    end else if (phase_q == PH_PIXELS) begin
      case (chan_q)
        2'd0: begin
          red_d  = cmd_i.data[7:3];
          chan_d = 2'd1;
        end
        2'd1: begin
          green_d = cmd_i.data[7:2];
          chan_d  = 2'd2;
        end
        default: begin
          px         = {red_q, green_q, cmd_i.data[7:3]};
          chan_d     = 2'd0;
          pix_left_d = pix_left_q - 1'b1;
          a_vld      = 1'b1;
          res_a      = make_res(KIND_PIXEL, '0, '0, px, '0, (pix_left_d == '0));
          if (pix_left_d == '0) begin
            phase_d = PH_DONE;
          end
        end
      endcase
    end

    if (do_add) begin
      if ((tok_len_d == 3'd0 && cmd_i.data != CH_P) ||
          (tok_len_d == 3'd1 && cmd_i.data != CH_SIX) || tok_len_d >= 3'd2) begin
        magic_d = 1'b0;
      end
      if (!cmd_i.is_digit) begin
        tok_nd_d = 1'b1;
      end else if (tok_len_d < 3'(MAX_DIGITS)) begin
        // value wraps at 17 bits
        val_x10   = {tok_val_d[13:0], 3'b000} + {tok_val_d[15:0], 1'b0} +
                    17'(cmd_i.data[3:0]);
        tok_val_d = val_x10;
      end
      if (tok_len_d < 3'(TOKEN_LEN_SAT)) begin
        tok_len_d = tok_len_d + 1'b1;
      end
    end

    // an open token is closed by a separator or by the end flag
    if (do_fin || (cmd_i.last && phase_q < PH_PIXELS && in_token_d)) begin
      in_token_d = 1'b0;
      dim_ok = !tok_nd_d && tok_len_d >= 3'd1 && tok_len_d <= 3'(MAX_DIGITS) &&
               tok_val_d >= 17'd1 && tok_val_d <= 17'(MAX_DIM);
      unique case (phase_q)
        PH_MAGIC: begin
          if (magic_d && tok_len_d == 3'd2) begin
            phase_d = PH_WIDTH;
          end else begin
            a_vld   = 1'b1;
            res_a   = make_res(KIND_ERROR, '0, '0, '0, ERR_MAGIC, 1'b1);
            phase_d = PH_DONE;
          end
        end
        PH_WIDTH: begin
          if (dim_ok) width_d = tok_val_d[12:0];
          else        dims_bad_d = 1'b1;
          phase_d = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          if (dim_ok) height_d = tok_val_d[12:0];
          else        dims_bad_d = 1'b1;
          phase_d = PH_MAXVAL;
        end
        PH_MAXVAL: begin
          a_vld = 1'b1;
          if (dims_bad_q) begin
            res_a   = make_res(KIND_ERROR, '0, '0, '0, ERR_DIMS, 1'b1);
            phase_d = PH_DONE;
          end else if (tok_nd_d || tok_len_d != 3'd3 || tok_val_d != 17'd255) begin
            res_a   = make_res(KIND_ERROR, '0, '0, '0, ERR_MAXVAL, 1'b1);
            phase_d = PH_DONE;
          end else begin
            res_a      = make_res(KIND_HEADER, width_q, height_q, '0, '0, 1'b0);
            pix_left_d = area;
            chan_d     = 2'd0;
            phase_d    = PH_PIXELS;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.last) begin
      if (phase_d == PH_MAGIC) begin
        b_vld = 1'b1;
        res_b = make_res(KIND_ERROR, '0, '0, '0, ERR_MAGIC, 1'b1);
      end else if (phase_d < PH_PIXELS) begin
        b_vld = 1'b1;
        res_b = make_res(KIND_ERROR, '0, '0, '0, ERR_HDR_TRUNC, 1'b1);
      end else if (phase_d == PH_PIXELS && pix_left_d != '0) begin
        b_vld = 1'b1;
        res_b = make_res(KIND_ERROR, '0, '0, '0, ERR_PIX_TRUNC, 1'b1);
      end
      // rearm for the next file
      phase_d      = PH_MAGIC;
      in_comment_d = 1'b0;
      in_token_d   = 1'b0;
      tok_len_d    = '0;
      tok_val_d    = '0;
      tok_nd_d     = 1'b0;
      magic_d      = 1'b1;
      width_d      = '0;
      height_d     = '0;
      dims_bad_d   = 1'b0;
      chan_d       = '0;
      red_d        = '0;
      green_d      = '0;
      pix_left_d   = '0;
    end
  end

  always_comb begin
    res_push_n_o = '0;
    res0_o       = res_a;
    res1_o       = res_b;
    if (fire) begin
      if (a_vld && b_vld) begin
        res_push_n_o = 2'd2;
      end else if (a_vld) begin
        res_push_n_o = 2'd1;
      end else if (b_vld) begin
        res_push_n_o = 2'd1;
        res0_o       = res_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_MAGIC;
      in_comment_q <= 1'b0;
      in_token_q   <= 1'b0;
      tok_len_q    <= '0;
      tok_val_q    <= '0;
      tok_nd_q     <= 1'b0;
      magic_q      <= 1'b1;
      width_q      <= '0;
      height_q     <= '0;
      dims_bad_q   <= 1'b0;
      chan_q       <= '0;
      red_q        <= '0;
      green_q      <= '0;
      pix_left_q   <= '0;
    end else if (fire) begin
      phase_q      <= phase_d;
      in_comment_q <= in_comment_d;
      in_token_q   <= in_token_d;
      tok_len_q    <= tok_len_d;
      tok_val_q    <= tok_val_d;
      tok_nd_q     <= tok_nd_d;
      magic_q      <= magic_d;
      width_q      <= width_d;
      height_q     <= height_d;
      dims_bad_q   <= dims_bad_d;
      chan_q       <= chan_d;
      red_q        <= red_d;
      green_q      <= green_d;
      pix_left_q   <= pix_left_d;
    end
  end

  `PPD_ASSERT_NEXT(a_last_rearms, clk_i, rst_ni, fire && cmd_i.last, phase_q == PH_MAGIC)
  `PPD_ASSERT_ALWAYS(a_pix_no_token, clk_i, rst_ni,
                     (phase_q != PH_PIXELS) || (!in_token_q && !in_comment_q))
  `PPD_ASSERT_ALWAYS(a_second_is_error, clk_i, rst_ni,
                     (res_push_n_o != 2'd2) || (res1_o.kind == KIND_ERROR))

endmodule

// ===== design/ppd_resq.sv =====
// Result queue: takes up to two result requests a cycle, releases one.
// Depends on ppd_pkg and the assertion macro header.
`include "ppm_p6_to_rgb565_stream_decoder_core_macros.svh"

module ppd_resq #(
  parameter int DEPTH = ppd_pkg::RES_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_n_i,
  input  ppd_pkg::res_t data0_i,
  input  ppd_pkg::res_t data1_i,
  output logic          space_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ppd_pkg::res_t data_o
);
  import ppd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, wr_nx, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // room for two requests, the most one byte can give
  assign space_o = (CW'(DEPTH) - cnt_q) >= CW'(2);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign wr_nx   = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push_n_i == 2'd1) begin
      wr_d = wr_nx;
    end else if (push_n_i == 2'd2) begin
      wr_d = (wr_nx == PW'(DEPTH - 1)) ? '0 : wr_nx + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + CW'(push_n_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_nx] <= data1_i;
    end
  end

  `PPD_ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(DEPTH))
  `PPD_ASSERT_ALWAYS(a_no_overfill, clk_i, rst_ni,
                     (CW'(push_n_i) + cnt_q) <= (CW'(DEPTH) + CW'(pop_i)))

endmodule

// ===== design/ppm_p6_to_rgb565_stream_decoder_core.sv =====
// Top level of the streaming PPM P6 to RGB565 decoder.
// Depends on ppd_pkg, ppd_front, ppd_cmdq, ppd_back and ppd_resq.
//
// Takes one file byte per request and sustains one byte per cycle. A byte
// enters a short queue (CMD_DEPTH entries) after classification; the parser
// takes one byte a cycle from it and writes zero, one or two result requests
// into the result queue (RES_DEPTH entries). The parser takes a byte only
// while the result queue has room for two requests, so the rate holds as
// long as the consumer takes results as fast as they arise; header, pixel
// and error results leave in file order. The end flag on a byte rearms the
// parser.
module ppm_p6_to_rgb565_stream_decoder_core #(
  parameter int CMD_DEPTH = ppd_pkg::CMD_DEPTH,
  parameter int RES_DEPTH = ppd_pkg::RES_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [12:0] image_width_o,
  output logic [12:0] image_height_o,
  output logic [15:0] rgb565_o,
  output logic [2:0]  error_code_o,
  output logic        final_res_o
);
  import ppd_pkg::*;

  logic       q_full, q_push, q_valid, q_pop, res_space;
  logic [1:0] res_push_n;
  cmd_t       cmd_in, cmd_out;
  res_t       res0, res1, res_head;

  ppd_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .q_full_i       (q_full),
    .push_o         (q_push),
    .cmd_o          (cmd_in)
  );

  ppd_cmdq #(.DEPTH(CMD_DEPTH)) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (cmd_out)
  );

  ppd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (q_pop),
    .res_space_i  (res_space),
    .res_push_n_o (res_push_n),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  ppd_resq #(.DEPTH(RES_DEPTH)) u_resq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (res_push_n),
    .data0_i  (res0),
    .data1_i  (res1),
    .space_o  (res_space),
    .pop_i    (out_valid_o && out_ready_i),
    .valid_o  (out_valid_o),
    .data_o   (res_head)
  );

  assign kind_o         = res_head.kind;
  assign image_width_o  = res_head.width;
  assign image_height_o = res_head.height;
  assign rgb565_o       = res_head.rgb565;
  assign error_code_o   = res_head.error_code;
  assign final_res_o    = res_head.final_res;

endmodule

// ===== bench/ppm_p6_to_rgb565_stream_decoder_core_tb.sv =====
// Self-checking bench for the PPM P6 to RGB565 stream decoder core.
// Uses ppd_pkg for result kinds, error codes and byte codes; drives the core
// from a byte queue and checks every result against a built-in decoder model.
`timescale 1ns / 1ps

module ppm_p6_to_rgb565_stream_decoder_core_tb;
  import ppd_pkg::*;

  typedef enum logic [2:0] {
    PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS, PH_DONE
  } parse_phase_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       hold;  // wait for all outstanding results before this request
  } byte_req_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [12:0] out_width;
  logic [12:0] out_height;
  logic [15:0] out_rgb565;
  logic [2:0]  out_error;
  logic        out_final;

  byte_req_t   file_bytes[$];
  logic [7:0]  file_buf[$];
  res_t        decoded_results[$];

  int          total_bytes = 0;
  int          bytes_done = 0;
  int          n_predicted = 0;
  int          results_due = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          send_gap = 0;
  int          take_gap = 0;
  logic        quiet_tail = 1'b0;

  // decoder model state
  parse_phase_e ph;
  logic        in_cmt, in_tok, tok_nondig, magic_ok, dims_bad;
  logic [2:0]  tok_len;
  logic [16:0] tok_val;
  logic [12:0] width_q, height_q;
  logic [1:0]  chan;
  logic [4:0]  red_q;
  logic [5:0]  green_q;
  logic [24:0] pix_left;

  ppm_p6_to_rgb565_stream_decoder_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (in_data),
    .end_of_input_i (in_last),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (out_kind),
    .image_width_o  (out_width),
    .image_height_o (out_height),
    .rgb565_o       (out_rgb565),
    .error_code_o   (out_error),
    .final_res_o    (out_final)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model
  task automatic clear_decoder();
    ph = PH_MAGIC;   in_cmt = 1'b0;  in_tok = 1'b0;   tok_len = '0;
    tok_val = '0;    tok_nondig = 1'b0; magic_ok = 1'b1; width_q = '0;
    height_q = '0;   dims_bad = 1'b0; chan = '0;      red_q = '0;
    green_q = '0;    pix_left = '0;
  endtask

  task automatic push_result(logic [1:0] k, logic [12:0] w, logic [12:0] h,
                             logic [15:0] px, logic [2:0] err, logic fin);
    decoded_results.push_back(res_t'{kind: k, width: w, height: h, rgb565: px,
                                     error_code: err, final_res: fin});
    n_predicted++;
  endtask

  task automatic raise_error(logic [2:0] err);
    push_result(KIND_ERROR, '0, '0, '0, err, 1'b1);
    ph = PH_DONE;
  endtask

  function automatic logic is_ws(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
  endfunction

  function automatic logic dim_ok();
    return !tok_nondig && tok_len >= 1 && tok_len <= MAX_DIGITS &&
           tok_val >= 1 && tok_val <= MAX_DIM;
  endfunction

  task automatic add_char(logic [7:0] b);
    logic [31:0] acc;
    if ((tok_len == 0 && b != CH_P) || (tok_len == 1 && b != CH_SIX) || tok_len >= 2)
      magic_ok = 1'b0;
    if (b < CH_ZERO || b > CH_NINE) begin
      tok_nondig = 1'b1;
    end else if (tok_len < MAX_DIGITS) begin
      acc = tok_val * 10 + (b - CH_ZERO);
      tok_val = acc[16:0];
    end
    if (tok_len < TOKEN_LEN_SAT) tok_len = tok_len + 3'd1;
  endtask

  task automatic finish_token();
    in_tok = 1'b0;
    case (ph)
      PH_MAGIC: begin
        if (magic_ok && tok_len == 2) ph = PH_WIDTH;
        else raise_error(ERR_MAGIC);
      end
      PH_WIDTH: begin
        if (dim_ok()) width_q = tok_val[12:0];
        else dims_bad = 1'b1;
        ph = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        if (dim_ok()) height_q = tok_val[12:0];
        else dims_bad = 1'b1;
        ph = PH_MAXVAL;
      end
      PH_MAXVAL: begin
        // bad dimensions take precedence over a bad maxval
        if (dims_bad) begin
          raise_error(ERR_DIMS);
        end else if (tok_nondig || tok_len != 3 || tok_val != 255) begin
          raise_error(ERR_MAXVAL);
        end else begin
          push_result(KIND_HEADER, width_q, height_q, '0, '0, 1'b0);
          pix_left = 25'(width_q) * 25'(height_q);
          chan = '0;
          ph = PH_PIXELS;
        end
      end
      default: ;
    endcase
  endtask

  task automatic decode_byte(logic [7:0] b, logic last);
    if (ph <= PH_MAXVAL) begin
      if (in_cmt) begin
        if (b == CH_LF) in_cmt = 1'b0;
      end else if (in_tok) begin
        if (is_ws(b)) finish_token();
        else add_char(b);
      end else if (!is_ws(b)) begin
        if (b == CH_HASH) begin
          in_cmt = 1'b1;
        end else begin
          in_tok = 1'b1;  tok_len = '0;  tok_val = '0;
          tok_nondig = 1'b0;  magic_ok = 1'b1;
          add_char(b);
        end
      end
    end else if (ph == PH_PIXELS) begin
      case (chan)
        2'd0: begin red_q = b[7:3]; chan = 2'd1; end
        2'd1: begin green_q = b[7:2]; chan = 2'd2; end
        default: begin
          chan = 2'd0;
          pix_left = pix_left - 25'd1;
          if (pix_left == 0) begin
            push_result(KIND_PIXEL, '0, '0, {red_q, green_q, b[7:3]}, '0, 1'b1);
            ph = PH_DONE;
          end else begin
            push_result(KIND_PIXEL, '0, '0, {red_q, green_q, b[7:3]}, '0, 1'b0);
          end
        end
      endcase
    end
    if (last) begin
      // an open token is closed by the end flag before the truncation checks
      if (ph <= PH_MAXVAL && in_tok) finish_token();
      if (ph == PH_MAGIC) raise_error(ERR_MAGIC);
      else if (ph <= PH_MAXVAL) raise_error(ERR_HDR_TRUNC);
      else if (ph == PH_PIXELS && pix_left != 0) raise_error(ERR_PIX_TRUNC);
      clear_decoder();
    end
  endtask

  // ------------------------------------------------------------ stimulus
  task automatic put_byte(logic [7:0] b);
    file_buf.push_back(b);
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
  endtask

  task automatic put_comment();
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 6);
    put_byte(CH_HASH);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      put_byte(b == CH_LF ? CH_HASH : b);
    end
    put_byte(CH_LF);
  endtask

  task automatic put_ws();
    case ($urandom_range(0, 3))
      0: put_byte(CH_SPACE);
      1: put_byte(CH_TAB);
      2: put_byte(CH_CR);
      default: put_byte(CH_LF);
    endcase
  endtask

  task automatic put_sep();
    int n;
    n = $urandom_range(1, 2);
    for (int i = 0; i < n; i++) put_ws();
    if ($urandom_range(0, 9) == 0) put_comment();
  endtask

  task automatic put_dim(int v);
    if (v < 10000 && $urandom_range(0, 5) == 0) put_str($sformatf("%05d", v));
    else put_str($sformatf("%0d", v));
  endtask

  task automatic put_noise(int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
  endtask

  // move the assembled file into the request queue, end flag on its last byte
  task automatic close_file(logic hold);
    byte_req_t r;
    if (file_buf.size() == 0) put_noise(1);
    for (int i = 0; i < file_buf.size(); i++) begin
      r.data = file_buf[i];
      r.last = (i == file_buf.size() - 1);
      r.hold = hold && (i == 0);
      file_bytes.push_back(r);
    end
    file_buf.delete();
  endtask

  task automatic random_file(logic hold);
    int sel, w, h, mode, ntok;
    logic big;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      big = ($urandom_range(0, 11) == 0);
      w = big ? $urandom_range(1, MAX_DIM) : $urandom_range(1, 4);
      h = big ? $urandom_range(1, MAX_DIM) : $urandom_range(1, 3);
      if ($urandom_range(0, 7) == 0) put_comment();
      if ($urandom_range(0, 7) == 0) put_ws();
      put_str("P6"); put_sep(); put_dim(w); put_sep(); put_dim(h); put_sep();
      put_str("255");
      mode = big ? 1 : $urandom_range(0, 9);
      if (mode == 0) begin
        // header ends on the final byte
      end else if (mode == 1) begin
        put_ws();
        put_noise($urandom_range(0, (3 * w * h - 1 < 20) ? 3 * w * h - 1 : 20));
      end else begin
        put_ws();
        put_noise(3 * w * h);
        if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 5));
      end
    end else begin
      case ($urandom_range(0, 5))
        0: put_noise($urandom_range(1, 12));
        1: begin
          case ($urandom_range(0, 5))
            0: put_str("P5");
            1: put_str("P");
            2: put_str("P66");
            3: put_str("p6");
            4: put_str("6P");
            default: put_str("P6x");
          endcase
          if ($urandom_range(0, 1)) begin
            put_sep(); put_str("2 2 255");
          end
        end
        2: begin
          put_str("P6"); put_sep();
          if ($urandom_range(0, 1)) begin
            put_dim($urandom_range(1, 4)); put_sep();
          end
          case ($urandom_range(0, 5))
            0: put_str("0");
            1: put_str("4097");
            2: put_str("000001");
            3: put_str("12a");
            4: put_str("99999");
            default: put_str("1234567");
          endcase
          put_sep(); put_dim($urandom_range(1, 4)); put_sep();
          put_str($urandom_range(0, 1) ? "255" : "256");
          put_ws();
        end
        3: begin
          put_str("P6"); put_sep(); put_dim($urandom_range(1, 4)); put_sep();
          put_dim($urandom_range(1, 4)); put_sep();
          case ($urandom_range(0, 5))
            0: put_str("256");
            1: put_str("0255");
            2: put_str("25");
            3: put_str("2550");
            4: put_str("25x");
            default: put_str("#");
          endcase
          put_ws(); put_noise($urandom_range(0, 4));
        end
        4: begin
          ntok = $urandom_range(0, 3);
          put_str("P6");
          if (ntok > 0) begin put_sep(); put_dim($urandom_range(1, MAX_DIM)); end
          if (ntok > 1) begin put_sep(); put_dim($urandom_range(1, MAX_DIM)); end
          if (ntok > 2 || $urandom_range(0, 1)) put_sep();
        end
        default: begin
          put_sep(); put_comment();
          if ($urandom_range(0, 1)) put_sep();
        end
      endcase
    end
    close_file(hold);
  endtask

  // ------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    logic      nxt_valid;
    byte_req_t req;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= 8'h00;
      in_last  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_data, in_last);
        bytes_done <= bytes_done + 1;
        if (!quiet_tail && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 3);
      end
      results_due <= n_predicted;
      quiet_tail  <= (file_bytes.size() < 150);
      nxt_valid = in_valid && !in_ready;
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (file_bytes.size() > 0 &&
                     !(file_bytes[0].hold && n_predicted != results_seen)) begin
          req = file_bytes.pop_front();
          nxt_valid = 1'b1;
          in_data <= req.data;
          in_last <= req.last;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // ------------------------------------------------------------ monitor
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    res_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (decoded_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind=%0d w=%0d h=%0d px=%h err=%0d fin=%0d",
                     out_kind, out_width, out_height, out_rgb565, out_error, out_final);
        end else begin
          want = decoded_results.pop_front();
          if (out_kind !== want.kind || out_width !== want.width ||
              out_height !== want.height || out_rgb565 !== want.rgb565 ||
              out_error !== want.error_code || out_final !== want.final_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want kind=%0d w=%0d h=%0d px=%h err=%0d fin=%0d",
                       want.kind, want.width, want.height, want.rgb565,
                       want.error_code, want.final_res,
                       " / got kind=%0d w=%0d h=%0d px=%h err=%0d fin=%0d",
                       out_kind, out_width, out_height, out_rgb565, out_error,
                       out_final);
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 5) == 0) take_gap = $urandom_range(1, 3);
      end
    end
  end

  // ---------------------------------------------------------- sequence
  initial begin : run_files
    int target;
    clear_decoder();

    // two pixels at the byte extremes, then a byte past the image
    put_str("P6 2 1 255"); put_byte(CH_LF);
    put_byte(8'h00); put_byte(8'h00); put_byte(8'h00);
    put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'h5A);
    close_file(1'b0);
    // leading comment, largest dimensions, end flag on the maxval token
    put_str("#c"); put_byte(CH_LF); put_str("P6"); put_byte(CH_TAB);
    put_str("4096"); put_byte(CH_CR); put_str("4096 255");
    close_file(1'b0);
    put_str("P5"); close_file(1'b1);                      // bad magic
    put_byte(CH_SPACE); put_byte(CH_LF); close_file(1'b0); // no token at all
    put_str("P6 12"); close_file(1'b0);                   // header cut short
    put_str("P6 123456 0 256 "); close_file(1'b0);        // long and zero dims
    put_str("P6 2 1 256 "); close_file(1'b0);             // bad maxval
    put_str("P6 1 2 255 "); put_noise(4); close_file(1'b0); // pixels cut short

    target = 1900;
    random_file(1'b1);
    while (file_bytes.size() < target) random_file($urandom_range(0, 24) == 0);
    total_bytes = file_bytes.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_done != total_bytes || results_due != results_seen) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && decoded_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
